// ===== hdl/clock_sweep_replacement_unit_macros.svh =====
// Assertion macros for the clock-sweep replacement unit.
// Included by the checker module; needs nothing else.
`ifndef CLOCK_SWEEP_REPLACEMENT_UNIT_MACROS_SVH
`define CLOCK_SWEEP_REPLACEMENT_UNIT_MACROS_SVH

// Checked only outside reset
`define CSWR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included
`define CSWR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cswr_pkg.sv =====
// Shared types, codes and sizes of the clock-sweep replacement unit.
// No dependencies; every other file but the macro header refers to it by scoped names.
package cswr_pkg;

   localparam int SLOTS      = 8;
   localparam int KEY_BITS   = 32;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int COUNT_BITS = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);

   localparam logic [COUNT_BITS-1:0] CAP_RESET = 3'd3;

   // Request mode codes
   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_ADD    = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;

   typedef enum logic [1:0] {
      OP_LOOKUP,
      OP_ADD,
      OP_TICK,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      STAT_MISS    = 3'd0,
      STAT_HIT     = 3'd1,
      STAT_PRESENT = 3'd2,
      STAT_FREE    = 3'd3,
      STAT_EVICT   = 3'd4,
      STAT_TICK    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_SWEEP,
      S_DONE
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [KEY_BITS-1:0] key;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

// ===== hdl/cswr_ifs.sv =====
// Channel interfaces of the clock-sweep replacement unit: request,
// response and register write. Depends on cswr_pkg.
interface cswr_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    mode;
   logic [cswr_pkg::KEY_BITS-1:0] key;
   modport source (output valid, mode, key, input ready);
   modport sink   (input valid, mode, key, output ready);
endinterface

interface cswr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [2:0]                    status;
   logic [2:0]                    slot;
   logic [cswr_pkg::KEY_BITS-1:0] evicted_key;
   modport source (output valid, status, slot, evicted_key, input ready);
   modport sink   (input valid, status, slot, evicted_key, output ready);
endinterface

interface cswr_csr_if;
   logic                            valid;
   logic                            ready;
   logic [cswr_pkg::COUNT_BITS-1:0] usage_cap;
   modport source (output valid, usage_cap, input ready);
   modport sink   (input valid, usage_cap, output ready);
endinterface

// ===== hdl/clock_sweep_replacement_unit.sv =====
// Clock-sweep replacement unit. A request passes the queue and the back
// end states S_IDLE, S_MATCH and S_DONE to the response register; add of a
// new key also passes S_SWEEP, where the hand inspects slots (at most 8 laps).
// The back end takes the next request only after the last result is loaded.
// Reset (synchronous): counts, occupied bits, hand and queue clear, cap=3.
// Built from cswr_front, cswr_queue, cswr_back; depends on cswr_pkg, cswr_ifs.
module clock_sweep_replacement_unit (
   input  logic       clock,
   input  logic       reset,
   cswr_req_if.sink   req_bus,
   cswr_rsp_if.source rsp_bus,
   cswr_csr_if.sink   csr_bus
);

   cswr_pkg::qstat_type qstat;
   cswr_pkg::cmd_type   push_cmd;
   cswr_pkg::cmd_type   pop_cmd;
   logic                push;
   logic                pop;

   // Classify and enqueue requests
   cswr_front u_front (
      .req      (req_bus),
      .qstat    (qstat),
      .push     (push),
      .push_cmd (push_cmd)
   );

   // Decouple front and back
   cswr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .qstat    (qstat)
   );

   // Execute against the slot table
   cswr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .qstat   (qstat),
      .pop_cmd (pop_cmd),
      .pop     (pop),
      .rsp     (rsp_bus),
      .csr     (csr_bus)
   );

endmodule

// ===== hdl/cswr_front.sv =====
// Front end: takes request transfers and classifies the mode into an op.
// Depends on cswr_pkg and cswr_req_if.
module cswr_front (
   cswr_req_if.sink             req,
   input  cswr_pkg::qstat_type  qstat,
   output logic                 push,
   output cswr_pkg::cmd_type    push_cmd
);

   // Accept whenever the queue has room
   assign req.ready = !qstat.full;
   assign push      = req.valid && !qstat.full;

   // Classify the mode; the unused code becomes OP_NONE, answered as a miss
   always_comb begin
      push_cmd.key = req.key;
      case (req.mode)
         cswr_pkg::MODE_LOOKUP: push_cmd.op = cswr_pkg::OP_LOOKUP;
         cswr_pkg::MODE_ADD:    push_cmd.op = cswr_pkg::OP_ADD;
         cswr_pkg::MODE_TICK:   push_cmd.op = cswr_pkg::OP_TICK;
         default:               push_cmd.op = cswr_pkg::OP_NONE;
      endcase
   end

endmodule

// ===== hdl/cswr_queue.sv =====
// Short command queue between front and back end.
// Depends on cswr_pkg.
module cswr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cswr_pkg::cmd_type    push_cmd,
   input  logic                 pop,
   output cswr_pkg::cmd_type    pop_cmd,
   output cswr_pkg::qstat_type  qstat
);

   cswr_pkg::cmd_type                entry_ff [cswr_pkg::QUEUE_DEPTH];
   logic [cswr_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [cswr_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [cswr_pkg::QPTR_BITS:0]     count_ff, count_in;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == cswr_pkg::QPTR_BITS'(cswr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == cswr_pkg::QPTR_BITS'(cswr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the payload
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd     = entry_ff[rd_ptr_ff];
   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == (cswr_pkg::QPTR_BITS + 1)'(cswr_pkg::QUEUE_DEPTH));

endmodule

// ===== hdl/cswr_back.sv =====
// Back end: slot table, clock hand, usage cap and the response register.
// Runs tag match, bump, decay tick and the hand sweep. Depends on cswr_pkg
// and the response and register-write interfaces.
module cswr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  cswr_pkg::qstat_type  qstat,
   input  cswr_pkg::cmd_type    pop_cmd,
   output logic                 pop,
   cswr_rsp_if.source           rsp,
   cswr_csr_if.sink             csr
);

   localparam int SB = cswr_pkg::SLOT_BITS;
   localparam int CB = cswr_pkg::COUNT_BITS;
   localparam int KB = cswr_pkg::KEY_BITS;

   cswr_pkg::state_type  state_ff, state_in;
   cswr_pkg::cmd_type    item_ff, item_in;
   logic [SB-1:0]        hand_ff, hand_in;
   logic [CB-1:0]        cap_ff;
   logic [CB-1:0]        usage_ff [cswr_pkg::SLOTS];
   logic [CB-1:0]        usage_in [cswr_pkg::SLOTS];
   logic [cswr_pkg::SLOTS-1:0] occ_ff, occ_in;
   logic [KB-1:0]        tag_ff [cswr_pkg::SLOTS];

   cswr_pkg::status_type res_status_ff, res_status_in;
   logic [SB-1:0]        res_slot_ff, res_slot_in;
   logic [KB-1:0]        res_evict_ff, res_evict_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   cswr_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [SB-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [KB-1:0]        rsp_evict_ff, rsp_evict_in;

   logic                 tag_we;
   logic [SB-1:0]        tag_waddr;

   logic [cswr_pkg::SLOTS-1:0] match;
   logic                 hit_any;
   logic [SB-1:0]        hit_idx;

   function automatic logic [SB-1:0] step_hand(input logic [SB-1:0] h);
      return (h == SB'(cswr_pkg::SLOTS - 1)) ? '0 : h + 1'b1;
   endfunction

   // Compare the key against every occupied slot; lowest match wins
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < cswr_pkg::SLOTS; i++) begin
         match[i] = occ_ff[i] && (tag_ff[i] == item_ff.key);
      end
      for (int i = cswr_pkg::SLOTS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = SB'(i);
         end
      end
      hit_any = |match;
   end

   // Sequencer: next state, table updates and result
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      hand_in       = hand_ff;
      occ_in        = occ_ff;
      usage_in      = usage_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_evict_in  = res_evict_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_evict_in  = rsp_evict_ff;
      tag_we        = 1'b0;
      tag_waddr     = hand_ff;
      pop           = 1'b0;

      case (state_ff)
         cswr_pkg::S_IDLE: begin
            if (!qstat.empty) begin
               pop      = 1'b1;
               item_in  = pop_cmd;
               state_in = cswr_pkg::S_MATCH;
            end
         end

         cswr_pkg::S_MATCH: begin
            res_status_in = cswr_pkg::STAT_MISS;
            res_slot_in   = '0;
            res_evict_in  = '0;
            state_in      = cswr_pkg::S_DONE;
            case (item_ff.op)
               cswr_pkg::OP_LOOKUP, cswr_pkg::OP_ADD: begin
                  if (hit_any) begin
                     if (usage_ff[hit_idx] < cap_ff) begin
                        usage_in[hit_idx] = usage_ff[hit_idx] + 1'b1;
                     end
                     res_status_in = (item_ff.op == cswr_pkg::OP_ADD) ?
                                     cswr_pkg::STAT_PRESENT : cswr_pkg::STAT_HIT;
                     res_slot_in   = hit_idx;
                  end else if (item_ff.op == cswr_pkg::OP_ADD) begin
                     state_in = cswr_pkg::S_SWEEP;
                  end
               end
               cswr_pkg::OP_TICK: begin
                  // Decay every occupied count above zero
                  for (int i = 0; i < cswr_pkg::SLOTS; i++) begin
                     if (occ_ff[i] && (usage_ff[i] != '0)) begin
                        usage_in[i] = usage_ff[i] - 1'b1;
                     end
                  end
                  res_status_in = cswr_pkg::STAT_TICK;
               end
               default: begin
               end
            endcase
         end

         cswr_pkg::S_SWEEP: begin
            // Inspect one slot at the hand per cycle
            if (!occ_ff[hand_ff] || (usage_ff[hand_ff] == '0)) begin
               res_status_in     = occ_ff[hand_ff] ? cswr_pkg::STAT_EVICT :
                                                     cswr_pkg::STAT_FREE;
               res_evict_in      = occ_ff[hand_ff] ? tag_ff[hand_ff] : '0;
               res_slot_in       = hand_ff;
               tag_we            = 1'b1;
               usage_in[hand_ff] = CB'(1);
               occ_in[hand_ff]   = 1'b1;
               hand_in           = step_hand(hand_ff);
               state_in          = cswr_pkg::S_DONE;
            end else begin
               usage_in[hand_ff] = usage_ff[hand_ff] - 1'b1;
               hand_in           = step_hand(hand_ff);
            end
         end

         cswr_pkg::S_DONE: begin
            // Hand the result to the response register once it is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_evict_in  = res_evict_ff;
               state_in      = cswr_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = cswr_pkg::S_IDLE;
         end
      endcase
   end

   // Control and table state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cswr_pkg::S_IDLE;
         hand_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= cswr_pkg::CAP_RESET;
         for (int i = 0; i < cswr_pkg::SLOTS; i++) begin
            usage_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         hand_ff      <= hand_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         usage_ff     <= usage_in;
         if (csr.valid) begin
            cap_ff <= csr.usage_cap;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_evict_ff  <= res_evict_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_evict_ff  <= rsp_evict_in;
   end

   // Tag store, written only on placement
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_ff[tag_waddr] <= item_ff.key;
      end
   end

   assign csr.ready       = 1'b1;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.slot        = 3'(rsp_slot_ff);
   assign rsp.evicted_key = rsp_evict_ff;

endmodule

// ===== hdl/cswr_checker.sv =====
// Port-level checker for the clock-sweep replacement unit, bound to the top.
// Depends on cswr_pkg and clock_sweep_replacement_unit_macros.svh.
`include "clock_sweep_replacement_unit_macros.svh"

module cswr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [2:0]                    rsp_status,
   input logic [2:0]                    rsp_slot,
   input logic [cswr_pkg::KEY_BITS-1:0] rsp_evicted_key
);

   // No response directly out of reset
   `CSWR_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "response valid after reset")

   // Only evictions carry a key
   `CSWR_ASSERT(a_evict_key, clock, reset, (rsp_valid && rsp_status != cswr_pkg::STAT_EVICT) |-> rsp_evicted_key == '0, "evicted key on non-eviction")

   // Miss and tick report slot zero
   `CSWR_ASSERT(a_slot_zero, clock, reset, (rsp_valid && (rsp_status == cswr_pkg::STAT_MISS || rsp_status == cswr_pkg::STAT_TICK)) |-> rsp_slot == '0, "slot set on miss or tick")

   // Stalled response holds
   `CSWR_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_slot) && $stable(rsp_evicted_key)), "stalled response changed")

endmodule

bind clock_sweep_replacement_unit cswr_checker u_cswr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_slot        (rsp_bus.slot),
   .rsp_evicted_key (rsp_bus.evicted_key)
);
